>>> hdl/i2cms_pkg.sv
package i2cms_pkg;

  localparam int unsigned RESET_CLOCKS_DEFAULT = 9;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
  localparam int unsigned BYTE_BITS = 8;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_RESET = 3'd5;

  localparam logic [2:0] KIND_TICK = 3'd0;

  localparam logic [4:0] PH_END = 5'd31;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       cmd_rejected;
  } res_t;

endpackage

>>> hdl/i2cms_seq.sv
module i2cms_seq #(
  parameter int unsigned RESET_CLOCKS = i2cms_pkg::RESET_CLOCKS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [2:0]        kind,
  input  logic [7:0]        tx_byte,
  input  logic              ack_level,
  input  logic              sda_in,
  input  logic [15:0]       phase_ticks,
  output i2cms_pkg::res_t   res
);
  import i2cms_pkg::*;

  localparam logic [4:0] RESET_LIMIT = 5'(RESET_CLOCKS);
  localparam logic [4:0] BYTE_LIMIT = 5'(BYTE_BITS);

  logic [2:0]  op, op_next;
  logic [4:0]  ph, ph_next;
  logic [3:0]  bitc, bitc_next;
  logic [7:0]  shift, shift_next;
  logic [15:0] wait_cnt, wait_cnt_next;
  logic        ack_hold, ack_hold_next;
  logic [2:0]  pins, pins_next;
  logic        nack, nack_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done, rejected;
  logic [15:0] unit;

  // Pins are packed as {drive, sda, scl}.
  function automatic logic [2:0] enter_pins(input logic [2:0] o, input logic [4:0] p,
                                            input logic msb, input logic ackv,
                                            input logic [2:0] cur);
    logic [2:0] r;
    logic [4:0] q;
    r = cur;
    q = p - 5'd4;
    unique case (o)
      OP_START: begin
        if (p == 5'd1) r[2:1] = 2'b11;
        else if (p == 5'd2) r[0] = 1'b1;
        else if (p == 5'd3) r[1] = 1'b0;
      end
      OP_WRITE: begin
        if (p == 5'd0) begin r[0] = 1'b0; r[2] = 1'b1; end
        else if (p == 5'd1) r[1] = msb;
        else if (p == 5'd2 || p == 5'd5) r[0] = 1'b1;
        else if (p == 5'd3 || p == 5'd6) r[0] = 1'b0;
        else if (p == 5'd4) r[2:1] = 2'b01;
      end
      OP_READ: begin
        if (p == 5'd0) begin r[0] = 1'b0; r[2] = 1'b0; end
        else if (p == 5'd1 || p == 5'd5) r[0] = 1'b1;
        else if (p == 5'd3 || p == 5'd7) r[0] = 1'b0;
        else if (p == 5'd4) r[2:1] = {1'b1, ackv};
      end
      OP_RESET: begin
        if (p == 5'd0) r = 3'b010;
        else if (p == 5'd2) r[0] = 1'b1;
        else if (p >= 5'd4) begin
          if (q == 5'd0) r[0] = 1'b0;
          else if (q == 5'd1) r[2:1] = 2'b10;
          else if (q == 5'd2) r[0] = 1'b1;
          else r[1] = 1'b1;
        end
      end
      OP_STOP: begin
        if (p == 5'd0) r[0] = 1'b0;
        else if (p == 5'd1) r[2:1] = 2'b10;
        else if (p == 5'd2) r[0] = 1'b1;
        else if (p == 5'd3) r[1] = 1'b1;
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  assign unit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  always_comb begin
    logic [4:0] nxt;
    logic [4:0] bit_inc;
    logic       is_cmd;
    op_next = op;
    ph_next = ph;
    bitc_next = bitc;
    shift_next = shift;
    wait_cnt_next = wait_cnt;
    ack_hold_next = ack_hold;
    pins_next = pins;
    nack_next = nack;
    rx_hold_next = rx_hold;
    done = 1'b0;
    rejected = 1'b0;
    nxt = PH_END;
    bit_inc = {1'b0, bitc} + 5'd1;
    is_cmd = (kind >= OP_START) && (kind <= OP_RESET);
    if (is_cmd) begin
      if (op != OP_IDLE) begin
        rejected = 1'b1;
      end else begin
        op_next = kind;
        ph_next = 5'd0;
        bitc_next = 4'd0;
        if (kind == OP_WRITE) shift_next = tx_byte;
        if (kind == OP_READ) begin
          shift_next = 8'd0;
          ack_hold_next = ack_level;
        end
        pins_next = enter_pins(kind, 5'd0, shift_next[7], ack_hold_next, pins);
        wait_cnt_next = unit;
      end
    end else if (op != OP_IDLE) begin
      if (wait_cnt > 16'd1) begin
        wait_cnt_next = wait_cnt - 16'd1;
      end else begin
        unique case (op)
          OP_START, OP_STOP: nxt = (ph >= 5'd3) ? PH_END : ph + 5'd1;
          OP_WRITE: begin
            if (ph == 5'd2) begin
              shift_next = {shift[6:0], 1'b0};
              if (bit_inc >= BYTE_LIMIT) begin
                bitc_next = 4'd0;
                nxt = 5'd3;
              end else begin
                bitc_next = bit_inc[3:0];
                nxt = 5'd0;
              end
            end else begin
              if (ph == 5'd5) nack_next = sda_in;
              nxt = (ph >= 5'd6) ? PH_END : ph + 5'd1;
            end
          end
          OP_READ: begin
            if (ph == 5'd1) shift_next = {shift[6:0], sda_in};
            if (ph == 5'd2) begin
              if (bit_inc >= BYTE_LIMIT) begin
                bitc_next = 4'd0;
                nxt = 5'd3;
              end else begin
                bitc_next = bit_inc[3:0];
                nxt = 5'd0;
              end
            end else begin
              nxt = (ph >= 5'd7) ? PH_END : ph + 5'd1;
            end
          end
          OP_RESET: begin
            if (ph == 5'd3) begin
              if (bit_inc >= RESET_LIMIT) begin
                bitc_next = 4'd0;
                nxt = 5'd4;
              end else begin
                bitc_next = bit_inc[3:0];
                nxt = 5'd0;
              end
            end else begin
              nxt = (ph >= 5'd7) ? PH_END : ph + 5'd1;
            end
          end
          default: nxt = PH_END;
        endcase
        if (nxt == PH_END) begin
          if (op == OP_STOP || op == OP_RESET) pins_next[2] = 1'b0;
          else if (op == OP_WRITE) pins_next[2] = 1'b1;
          else if (op == OP_READ) rx_hold_next = shift_next;
          op_next = OP_IDLE;
          ph_next = 5'd0;
          bitc_next = 4'd0;
          wait_cnt_next = 16'd0;
          done = 1'b1;
        end else begin
          ph_next = nxt;
          pins_next = enter_pins(op, nxt, shift_next[7], ack_hold, pins);
          wait_cnt_next = unit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_IDLE;
      ph <= 5'd0;
      bitc <= 4'd0;
      shift <= 8'd0;
      wait_cnt <= 16'd0;
      ack_hold <= 1'b1;
      pins <= 3'b011;
      nack <= 1'b0;
      rx_hold <= 8'd0;
    end else if (step) begin
      op <= op_next;
      ph <= ph_next;
      bitc <= bitc_next;
      shift <= shift_next;
      wait_cnt <= wait_cnt_next;
      ack_hold <= ack_hold_next;
      pins <= pins_next;
      nack <= nack_next;
      rx_hold <= rx_hold_next;
    end
  end

  always_comb begin
    res.scl_level = pins_next[0];
    res.sda_level = pins_next[1];
    res.sda_drive = pins_next[2];
    res.ready_res = (op_next == OP_IDLE);
    res.done_res = done;
    res.rx_byte = rx_hold_next;
    res.nack_seen = nack_next;
    res.cmd_rejected = rejected;
  end

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    step && done |=> op == OP_IDLE && wait_cnt == 16'd0)
    else $error("Sequencer did not return to idle after a finished command.");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    step && rejected |=> op == $past(op) && wait_cnt == $past(wait_cnt))
    else $error("A rejected command disturbed the running command.");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    op != OP_IDLE |-> ph <= 5'd7 && wait_cnt != 16'd0)
    else $error("Active command has an invalid phase or timer.");

endmodule

>>> hdl/i2c_master_bit_sequencer_top.sv
// I2C master line sequencer.
// Requests arrive on the input channel (in_valid, in_stall) and carry a kind:
// a tick, or a start, stop, write byte, read byte or bus reset command. Every
// accepted request yields exactly one result on the output channel
// (out_valid, out_stall) holding the SCL, SDA and SDA drive levels, the idle
// and done flags, the last received byte, the last acknowledge level and a
// flag for a command that was ignored because the sequencer was busy.
// Each pin phase lasts phase_ticks tick requests; phase_ticks is written
// through cfg_write_en and cfg_write_data; the user must do so only while
// the block is idle, as the block itself does not enforce this.
// A request is accepted in the cycle it is offered while in_stall is low,
// and its result is registered into the output register, or into the skid
// register while the output stalls; one request per cycle while in_stall is low.
// When the receiver stalls, the result waiting in the output register holds
// and one more request is taken into a skid register; in_stall then rises
// until the output drains.
// Synchronous reset empties both registers, sets phase_ticks to 100, and
// leaves SCL high with SDA released.
module i2c_master_bit_sequencer_top #(
  parameter int unsigned RESET_CLOCKS = i2cms_pkg::RESET_CLOCKS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  tx_byte,
  input  logic        ack_level,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        ready_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        nack_seen,
  output logic        cmd_rejected,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);
  import i2cms_pkg::*;

  logic [15:0] phase_ticks;
  logic        accept;
  res_t        res;
  res_t        out_res;
  res_t        skid_res;
  logic        skid_valid;

  assign in_stall = skid_valid;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_write_en) begin
      phase_ticks <= cfg_write_data;
    end
  end

  i2cms_seq #(
    .RESET_CLOCKS(RESET_CLOCKS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .ack_level  (ack_level),
    .sda_in     (sda_in),
    .phase_ticks(phase_ticks),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (accept) begin
      out_res <= res;
    end
  end

  assign scl_level = out_res.scl_level;
  assign sda_level = out_res.sda_level;
  assign sda_drive = out_res.sda_drive;
  assign ready_res = out_res.ready_res;
  assign done_res = out_res.done_res;
  assign rx_byte = out_res.rx_byte;
  assign nack_seen = out_res.nack_seen;
  assign cmd_rejected = out_res.cmd_rejected;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid register holds a result while the output register is empty.");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("An accepted request produced no result.");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid && out_valid)
    else $error("Skid register did not move to the output when it drained.");

endmodule
